### hw/rtl/cks_pkg.sv
// shared types and constants for the color key span encoder
`default_nettype none

package cks_pkg;

  // output field widths
  localparam int LINE_NUM_W  = 10;
  localparam int START_COL_W = 10;
  localparam int RUN_LEN_W   = 11;
  localparam int LINE_RUNS_W = 10;
  localparam int RUN_NUM_W   = 19;

  // register fields
  localparam int COLOR_W = 24;
  localparam int DIM_W   = 11;

  // apb port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_KEY_COLOR  = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd1;
  localparam logic [1:0] REG_LINE_COUNT = 2'd2;

  // register reset values
  localparam logic [COLOR_W-1:0] KEY_COLOR_RST  = 24'h00FF00;
  localparam logic [DIM_W-1:0]   LINE_WIDTH_RST = 11'd1024;
  localparam logic [DIM_W-1:0]   LINE_COUNT_RST = 11'd1024;

  // record kinds
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // one pixel request
  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               frame_start;
  } pixel_req_t;

  // one result record
  typedef struct packed {
    logic                   kind;
    logic [LINE_NUM_W-1:0]  line_number;
    logic [START_COL_W-1:0] start_column;
    logic [RUN_LEN_W-1:0]   run_length;
    logic [LINE_RUNS_W-1:0] line_run_count;
    logic [RUN_NUM_W-1:0]   run_number;
    logic                   last;
  } span_rec_t;

  // records produced by one pixel, handed to the result queue
  typedef struct packed {
    logic [1:0] count;
    span_rec_t  first;
    span_rec_t  second;
  } rec_push_t;

endpackage

`default_nettype wire

### hw/rtl/cks_regs.sv
// apb configuration registers and clamped image bounds
`default_nettype none

module cks_regs import cks_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic      [DATA_W-1:0]    prdata,
  output logic                      pready,
  output logic      [COLOR_W-1:0]   key_color,
  output logic [$clog2(MAX_WIDTH)-1:0] last_col,
  output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] last_line
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LNW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int HCW = (LNW + 1 > DIM_W) ? LNW + 1 : DIM_W;

  logic [DIM_W-1:0] line_width;
  logic [DIM_W-1:0] line_count;
  logic             wr_en;
  logic [WCW-1:0]   width_ext;
  logic [HCW-1:0]   count_ext;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_color  <= KEY_COLOR_RST;
      line_width <= LINE_WIDTH_RST;
      line_count <= LINE_COUNT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_KEY_COLOR:  key_color  <= pwdata[COLOR_W-1:0];
        REG_LINE_WIDTH: line_width <= pwdata[DIM_W-1:0];
        REG_LINE_COUNT: line_count <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      REG_KEY_COLOR:  prdata = DATA_W'(key_color);
      REG_LINE_WIDTH: prdata = DATA_W'(line_width);
      REG_LINE_COUNT: prdata = DATA_W'(line_count);
      default:        prdata = '0;
    endcase
  end

  // last column index, width clamped to 1..MAX_WIDTH
  assign width_ext = WCW'(line_width);
  always_comb begin
    if (line_width == '0) begin
      last_col = '0;
    end else if (width_ext >= WCW'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(width_ext - WCW'(1));
    end
  end

  // last line index, count clamped to 1..MAX_HEIGHT
  assign count_ext = HCW'(line_count);
  always_comb begin
    if (line_count == '0) begin
      last_line = '0;
    end else if (count_ext >= HCW'(MAX_HEIGHT)) begin
      last_line = LNW'(MAX_HEIGHT - 1);
    end else begin
      last_line = LNW'(count_ext - HCW'(1));
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cks_core.sv
// pixel input register, position and run state, record generation
`default_nettype none

module cks_core import cks_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pix_valid,
  output logic                      pix_stall,
  input  wire pixel_req_t           pix,
  input  wire logic [COLOR_W-1:0]   key_color,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] last_col,
  input  wire logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] last_line,
  input  wire logic                 room,
  output rec_push_t                 push
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LNW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // input register
  logic               hold_valid;
  logic [COLOR_W-1:0] hold_pixel;
  logic               hold_fs;
  logic               fire;
  logic               accept;

  // scan state
  logic [CW-1:0]          column, column_next;
  logic [LNW-1:0]         line, line_next;
  logic                   in_run, in_run_next;
  logic [CW-1:0]          run_start, run_start_next;
  logic [LINE_RUNS_W-1:0] runs_in_line, runs_in_line_next;
  logic [RUN_NUM_W-1:0]   runs_in_frame, runs_in_frame_next;

  // working values
  logic [CW-1:0]          col_e, start_e, run_from;
  logic [LNW-1:0]         line_e;
  logic                   run_e;
  logic [LINE_RUNS_W-1:0] ril_e, ril_a;
  logic [RUN_NUM_W-1:0]   rif_e, rif_a;
  logic                   opaque, line_end, close_key, close_end, run_emit;
  logic [CW:0]            run_len;
  span_rec_t              run_rec, sum_rec;

  assign fire      = hold_valid & room;
  assign pix_stall = hold_valid & ~room;
  assign accept    = pix_valid & ~pix_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold_pixel <= pix.pixel_color;
      hold_fs    <= pix.frame_start;
    end
  end

  // frame start clears position and counters first
  always_comb begin
    col_e   = hold_fs ? '0 : column;
    line_e  = hold_fs ? '0 : line;
    run_e   = hold_fs ? 1'b0 : in_run;
    start_e = hold_fs ? '0 : run_start;
    ril_e   = hold_fs ? '0 : runs_in_line;
    rif_e   = hold_fs ? '0 : runs_in_frame;
  end

  // run tracking: key pixel closes, line end closes with this pixel
  always_comb begin
    opaque    = hold_pixel != key_color;
    line_end  = col_e >= last_col;
    close_key = run_e & ~opaque;
    close_end = line_end & opaque;
    run_emit  = close_key | close_end;
    run_from  = run_e ? start_e : col_e;
    run_len   = {1'b0, col_e} - {1'b0, run_from} + (CW + 1)'(close_end);
    ril_a     = ril_e + LINE_RUNS_W'(run_emit);
    rif_a     = rif_e + RUN_NUM_W'(run_emit);
  end

  // records
  always_comb begin
    run_rec.kind           = KIND_RUN;
    run_rec.line_number    = LINE_NUM_W'(line_e);
    run_rec.start_column   = START_COL_W'(run_from);
    run_rec.run_length     = RUN_LEN_W'(run_len);
    run_rec.line_run_count = ril_e;
    run_rec.run_number     = rif_e;
    run_rec.last           = ~line_end;

    sum_rec.kind           = KIND_SUMMARY;
    sum_rec.line_number    = LINE_NUM_W'(line_e);
    sum_rec.start_column   = '0;
    sum_rec.run_length     = '0;
    sum_rec.line_run_count = ril_a;
    sum_rec.run_number     = rif_a;
    sum_rec.last           = 1'b1;

    push.first  = run_emit ? run_rec : sum_rec;
    push.second = sum_rec;
    if (!fire) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'({1'b0, run_emit} + {1'b0, line_end});
    end
  end

  // next scan state
  always_comb begin
    run_start_next = run_from;
    if (line_end) begin
      column_next       = '0;
      in_run_next       = 1'b0;
      runs_in_line_next = '0;
      if (line_e >= last_line) begin
        line_next          = '0;
        runs_in_frame_next = '0;
      end else begin
        line_next          = line_e + LNW'(1);
        runs_in_frame_next = rif_a;
      end
    end else begin
      column_next        = col_e + CW'(1);
      in_run_next        = opaque;
      runs_in_line_next  = ril_a;
      line_next          = line_e;
      runs_in_frame_next = rif_a;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      line          <= '0;
      in_run        <= 1'b0;
      run_start     <= '0;
      runs_in_line  <= '0;
      runs_in_frame <= '0;
    end else if (fire) begin
      column        <= column_next;
      line          <= line_next;
      in_run        <= in_run_next;
      run_start     <= run_start_next;
      runs_in_line  <= runs_in_line_next;
      runs_in_frame <= runs_in_frame_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cks_fifo.sv
// four-entry result queue, up to two pushes and one pop per cycle
`default_nettype none

module cks_fifo import cks_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rec_push_t push,
  output logic           room,
  output logic           rec_valid,
  input  wire logic      rec_stall,
  output span_rec_t      rec
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  span_rec_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count, count_next;
  logic            pop;

  assign rec_valid = count != '0;
  assign rec       = mem[rd_ptr];
  assign pop       = rec_valid & ~rec_stall;
  assign room      = count <= (PW + 1)'(DEPTH - 2);

  always_comb begin
    count_next = count + (PW + 1)'(push.count) - (PW + 1)'(pop);
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/color_key_span_encoder.sv
// top level of the color key span encoder
//
//   channel  direction  handshake               payload
//   pix      in         pix_valid / pix_stall   pixel_req_t
//   rec      out        rec_valid / rec_stall   span_rec_t
//   apb      in         psel / penable / pready key_color, line_width, line_count
//
// one pixel per cycle while pix_stall is low: a pixel is held in the input
// register, then the compare and counter logic writes its records into the
// queue. a pixel that ends a line and closes a run makes two records; the queue
// drains one record per cycle while rec_stall is low, which bounds output at one
// per cycle. rst is synchronous: it clears position, run state and the queue and
// loads register defaults. pix_stall rises when a pixel is held and two queue entries are not free.
`default_nettype none

module color_key_span_encoder import cks_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              pix_valid,
  output logic                   pix_stall,
  input  wire pixel_req_t        pix,
  output logic                   rec_valid,
  input  wire logic              rec_stall,
  output span_rec_t              rec
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LNW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [COLOR_W-1:0] key_color;
  logic [CW-1:0]      last_col;
  logic [LNW-1:0]     last_line;
  logic               room;
  rec_push_t          push;

  // configuration registers
  cks_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_color (key_color),
    .last_col  (last_col),
    .last_line (last_line)
  );

  // scan and run logic
  cks_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .key_color (key_color),
    .last_col  (last_col),
    .last_line (last_line),
    .room      (room),
    .push      (push)
  );

  // result queue
  cks_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the color key span encoder
`timescale 1ns / 1ps

module testbench;
  import cks_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_DIM       = 1024;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 440;
  localparam int HOLD_AT       = 800;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int SHOWN_ERRORS  = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              pix_valid = 1'b0;
  logic              pix_stall;
  pixel_req_t        pix = '0;
  logic              rec_valid;
  logic              rec_stall = 1'b0;
  span_rec_t         rec;

  // predicted position, run state and register copies
  logic [COLOR_W-1:0]     key_reg;
  logic [DIM_W-1:0]       width_reg;
  logic [DIM_W-1:0]       count_reg;
  logic [9:0]             cur_col;
  logic [9:0]             cur_line;
  logic                   run_open;
  logic [9:0]             open_start;
  logic [LINE_RUNS_W-1:0] line_runs;
  logic [RUN_NUM_W-1:0]   frame_runs;

  span_rec_t expected_recs[$];
  int        mismatches = 0;
  int        pixels_in = 0;
  int        cycle_count = 0;
  bit        no_gaps = 1'b0;

  color_key_span_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec)
  );

  // clock
  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > MAX_DIM) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [COLOR_W-1:0] opaque_color();
    logic [COLOR_W-1:0] c;
    do c = COLOR_W'($urandom); while (c == key_reg);
    return c;
  endfunction

  function automatic string rec_text(input span_rec_t r);
    return $sformatf("kind=%0d line=%0d col=%0d len=%0d idx=%0d num=%0d last=%0d",
                     r.kind, r.line_number, r.start_column, r.run_length,
                     r.line_run_count, r.run_number, r.last);
  endfunction

  // close the open run and advance the run counters
  function automatic span_rec_t close_run(input logic [RUN_LEN_W-1:0] len);
    span_rec_t r;
    r = '0;
    r.kind           = KIND_RUN;
    r.line_number    = cur_line;
    r.start_column   = open_start;
    r.run_length     = len;
    r.line_run_count = line_runs;
    r.run_number     = frame_runs;
    line_runs  = line_runs + 1'b1;
    frame_runs = frame_runs + 1'b1;
    run_open   = 1'b0;
    return r;
  endfunction

  // records caused by one accepted pixel
  task automatic predict_spans(input pixel_req_t p);
    span_rec_t          made [2];
    int                 n;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic               opaque;
    logic               at_end;
    n = 0;
    w = clamp_dim(width_reg);
    h = clamp_dim(count_reg);
    opaque = (p.pixel_color != key_reg);
    if (p.frame_start) begin
      cur_col    = '0;
      cur_line   = '0;
      run_open   = 1'b0;
      open_start = '0;
      line_runs  = '0;
      frame_runs = '0;
    end
    at_end = ({1'b0, cur_col} >= w - 1'b1);
    // key pixel ends the open run before this column
    if (run_open && !opaque) begin
      made[n] = close_run({1'b0, cur_col} - {1'b0, open_start});
      n++;
    end
    if (opaque && !run_open) begin
      run_open   = 1'b1;
      open_start = cur_col;
    end
    // line end: flush the run with this pixel, then the summary
    if (at_end) begin
      if (run_open) begin
        made[n] = close_run({1'b0, cur_col} - {1'b0, open_start} + 1'b1);
        n++;
      end
      made[n] = '0;
      made[n].kind           = KIND_SUMMARY;
      made[n].line_number    = cur_line;
      made[n].line_run_count = line_runs;
      made[n].run_number     = frame_runs;
      n++;
      line_runs = '0;
      cur_col   = '0;
      if ({1'b0, cur_line} >= h - 1'b1) begin
        cur_line   = '0;
        frame_runs = '0;
      end else begin
        cur_line = cur_line + 1'b1;
      end
    end else begin
      cur_col = cur_col + 1'b1;
    end
    if (n > 0) made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_recs.push_back(made[i]);
  endtask

  // compare each accepted record with the oldest expectation
  always @(posedge clk) begin
    span_rec_t want;
    if (!rst && rec_valid && !rec_stall) begin
      if (expected_recs.size() == 0) begin
        if (mismatches < SHOWN_ERRORS)
          $display("unexpected record: %s", rec_text(rec));
        mismatches++;
      end else begin
        want = expected_recs.pop_front();
        if (rec.kind !== want.kind || rec.line_number !== want.line_number ||
            rec.start_column !== want.start_column ||
            rec.run_length !== want.run_length ||
            rec.line_run_count !== want.line_run_count ||
            rec.run_number !== want.run_number || rec.last !== want.last) begin
          if (mismatches < SHOWN_ERRORS) begin
            $display("record mismatch at cycle %0d", cycle_count);
            $display("  expected %s", rec_text(want));
            $display("  actual   %s", rec_text(rec));
          end
          mismatches++;
        end
      end
    end
  end

  // result stall: random stretches plus one long hold-off
  initial begin : result_stall_gen
    bit hold_done;
    bit stall_turn;
    int span;
    hold_done  = 1'b0;
    stall_turn = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && pixels_in >= HOLD_AT) begin
        hold_done = 1'b1;
        span = HOLD_CYCLES;
        rec_stall <= 1'b1;
      end else begin
        stall_turn = ~stall_turn;
        if (stall_turn)
          span = gap_len() + 1;
        else if ($urandom_range(0, 9) == 0)
          span = $urandom_range(50, 150);
        else
          span = $urandom_range(1, 12);
        rec_stall <= stall_turn;
      end
      repeat (span - 1) @(negedge clk);
    end
  end

  // offer one pixel request and wait until it is taken
  task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic fs);
    pixel_req_t req;
    int         gap;
    req.pixel_color = color;
    req.frame_start = fs;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      pix_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix       <= req;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    pixels_in++;
    predict_spans(req);
  endtask

  // stop offering and let every expected record come out
  task automatic wait_idle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (expected_recs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_KEY_COLOR:  key_reg   = value[COLOR_W-1:0];
      REG_LINE_WIDTH: width_reg = value[DIM_W-1:0];
      REG_LINE_COUNT: count_reg = value[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // reset key and dimensions
  task automatic test_reset_defaults();
    send_pixel(opaque_color(), 1'b1);
    send_pixel(opaque_color(), 1'b0);
    send_pixel(KEY_COLOR_RST, 1'b0);
    send_pixel(opaque_color(), 1'b0);
    wait_idle();
  endtask

  // runs closed by key pixels and by line ends, frame wrap
  task automatic test_line_ends();
    write_reg(REG_KEY_COLOR, 32'h0000_0000);
    write_reg(REG_LINE_WIDTH, 32'd4);
    write_reg(REG_LINE_COUNT, 32'd2);
    // single-pixel run at the line end
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    // key pixel at the line end closes the run, last line wraps
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    // empty line after wrap
    repeat (4) send_pixel(24'h000000, 1'b0);
    wait_idle();
  endtask

  // zero width acts as one pixel per line
  task automatic test_narrow_lines();
    write_reg(REG_KEY_COLOR, 32'h00FF_FFFF);
    write_reg(REG_LINE_WIDTH, 32'd0);
    write_reg(REG_LINE_COUNT, 32'd3);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h000000, 1'b0);
    wait_idle();
  endtask

  // shrinking width and count with the position past the new bounds
  task automatic test_bounds_shrink();
    write_reg(REG_KEY_COLOR, $urandom);
    write_reg(REG_LINE_WIDTH, 32'd8);
    write_reg(REG_LINE_COUNT, 32'd4);
    send_pixel(opaque_color(), 1'b1);
    repeat (5) send_pixel(opaque_color(), 1'b0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 32'd4);
    send_pixel(key_reg, 1'b0);
    wait_idle();
    write_reg(REG_LINE_COUNT, 32'd1);
    repeat (5) send_pixel(opaque_color(), 1'b0);
    wait_idle();
  endtask

  // frame start in the middle of an open run
  task automatic test_frame_start();
    write_reg(REG_LINE_WIDTH, 32'd6);
    write_reg(REG_LINE_COUNT, 32'd3);
    repeat (3) send_pixel(opaque_color(), 1'b0);
    send_pixel(opaque_color(), 1'b1);
    send_pixel(key_reg, 1'b0);
    repeat (4) send_pixel(opaque_color(), 1'b0);
    wait_idle();
  endtask

  // random settings and mostly well-formed runs
  task automatic test_random_frames();
    int                 sent;
    int                 phase_len;
    int                 mode;
    int                 seg;
    bit                 want_opaque;
    bit                 fs;
    logic [COLOR_W-1:0] c;
    logic [DATA_W-1:0]  junk;
    logic [DIM_W-1:0]   dim;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      junk = ($urandom_range(0, 7) == 0) ? $urandom : '0;
      case ($urandom_range(0, 5))
        0:       c = 24'h000000;
        1:       c = 24'hFFFFFF;
        default: c = COLOR_W'($urandom);
      endcase
      write_reg(REG_KEY_COLOR, {junk[31:24], c});
      case ($urandom_range(0, 9))
        0:       dim = '0;
        1:       dim = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
        2:       dim = DIM_W'($urandom_range(13, 40));
        default: dim = DIM_W'($urandom_range(1, 12));
      endcase
      write_reg(REG_LINE_WIDTH, {junk[31:11], dim});
      case ($urandom_range(0, 7))
        0:       dim = '0;
        1:       dim = DIM_W'($urandom_range(7, 2047));
        default: dim = DIM_W'($urandom_range(1, 6));
      endcase
      write_reg(REG_LINE_COUNT, {junk[31:11], dim});
      no_gaps   = ($urandom_range(0, 3) == 0);
      mode      = $urandom_range(0, 9);
      phase_len = $urandom_range(16, 100);
      seg       = 0;
      want_opaque = 1'b0;
      for (int i = 0; i < phase_len; i++) begin
        if (seg == 0) begin
          want_opaque = ~want_opaque;
          seg = $urandom_range(1, 6);
        end
        seg--;
        if (mode < 6)
          c = want_opaque ? opaque_color() : key_reg;
        else if (mode < 8)
          c = ($urandom_range(0, 2) == 0) ? key_reg : opaque_color();
        else
          c = COLOR_W'($urandom);
        fs = (i == 0 && $urandom_range(0, 1) == 1) ||
             (mode >= 8 && $urandom_range(0, 15) == 0);
        send_pixel(c, fs);
      end
      sent += phase_len;
    end
    no_gaps = 1'b0;
  endtask

  // one fully opaque line at the widest setting
  task automatic test_full_width_line();
    wait_idle();
    write_reg(REG_LINE_WIDTH, 32'd2047);
    write_reg(REG_LINE_COUNT, 32'd2);
    no_gaps = 1'b1;
    send_pixel(opaque_color(), 1'b1);
    repeat (MAX_DIM - 1) send_pixel(opaque_color(), 1'b0);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  initial begin
    key_reg    = KEY_COLOR_RST;
    width_reg  = LINE_WIDTH_RST;
    count_reg  = LINE_COUNT_RST;
    cur_col    = '0;
    cur_line   = '0;
    run_open   = 1'b0;
    open_start = '0;
    line_runs  = '0;
    frame_runs = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_line_ends();
    test_narrow_lines();
    test_bounds_shrink();
    test_frame_start();
    test_random_frames();
    test_full_width_line();

    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cks_pkg.sv
hw/rtl/cks_regs.sv
hw/rtl/cks_core.sv
hw/rtl/cks_fifo.sv
hw/rtl/color_key_span_encoder.sv
verif/testbench.sv
